[rtl/sd_card_spi_slave_top_assert.svh]
// Assertion macros for the SD card SPI slave.
`ifndef SD_CARD_SPI_SLAVE_TOP_ASSERT_SVH
`define SD_CARD_SPI_SLAVE_TOP_ASSERT_SVH
// implication in the same cycle
`define SDSP_ASSERT_IMP(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("sdsp assertion failed");
// implication in the next cycle
`define SDSP_ASSERT_NXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("sdsp assertion failed");
`endif

[rtl/sdsp_pkg.sv]
// ----------------------------------------------------------------------------
// sdsp_pkg
// Shared types and constants for the SD card SPI slave.
// ----------------------------------------------------------------------------
package sdsp_pkg;
   localparam int BlockBytes = 512;
   localparam int NumBlocks  = 64;
   localparam int BufAw      = 9;

   localparam logic [1:0] FUNC_BYTE = 2'd0;
   localparam logic [1:0] FUNC_WORD = 2'd1;
   localparam logic [1:0] FUNC_SEL  = 2'd2;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   // command indexes
   localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
   localparam logic [5:0] CMD_SEND_IF     = 6'd8;
   localparam logic [5:0] CMD_READ_BLOCK  = 6'd17;
   localparam logic [5:0] CMD_WRITE_BLOCK = 6'd24;
   localparam logic [5:0] CMD_APP_INIT    = 6'd41;
   localparam logic [5:0] CMD_APP_CMD     = 6'd55;
   localparam logic [5:0] CMD_READ_OCR    = 6'd58;

   typedef struct packed {
      logic             we;
      logic [BufAw-1:0] addr;
      logic [7:0]       data;
   } buf_wr_type;
endpackage

[rtl/sdsp_store.sv]
// ----------------------------------------------------------------------------
// sdsp_store
// Block store and receive buffer, with the post-reset clear and block copy.
// ----------------------------------------------------------------------------
module sdsp_store #(
   parameter int NUM_BLOCKS = sdsp_pkg::NumBlocks,
   parameter int DEPTH      = NUM_BLOCKS * sdsp_pkg::BlockBytes,
   parameter int ADDR_W     = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [7:0]           rd_data,
   input  sdsp_pkg::buf_wr_type buf_wr,
   input  logic                 copy_start,
   input  logic [ADDR_W-1:0]    copy_base,
   output logic                 busy
);
   logic [7:0] disk [DEPTH];
   logic [7:0] rbuf [sdsp_pkg::BlockBytes];

   logic              clr_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic              cp_ff;
   logic [9:0]        cp_cnt_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [7:0]        rbuf_q_ff;
   logic [7:0]        rd_q_ff;
   logic [8:0]        wr_off;

   assign wr_off  = 9'(cp_cnt_ff - 10'd1);
   assign busy    = clr_ff | cp_ff;
   assign rd_data = rd_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         cp_ff      <= 1'b0;
         cp_cnt_ff  <= '0;
      end else begin
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) clr_ff <= 1'b0;
         end
         if (copy_start) begin
            cp_ff     <= 1'b1;
            cp_cnt_ff <= '0;
         end else if (cp_ff) begin
            cp_cnt_ff <= cp_cnt_ff + 10'd1;
            if (cp_cnt_ff == 10'(sdsp_pkg::BlockBytes)) cp_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (copy_start) base_ff <= copy_base;
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         disk[clr_cnt_ff] <= 8'h00;
      end else if (cp_ff && cp_cnt_ff != 10'd0) begin
         disk[base_ff + ADDR_W'(wr_off)] <= rbuf_q_ff;
      end
      rd_q_ff <= disk[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (buf_wr.we) rbuf[buf_wr.addr] <= buf_wr.data;
      rbuf_q_ff <= rbuf[cp_cnt_ff[8:0]];
   end
endmodule

[rtl/sdsp_engine.sv]
// ----------------------------------------------------------------------------
// sdsp_engine
// Byte engine: card state machine, one byte exchange or select change per run.
// ----------------------------------------------------------------------------
module sdsp_engine #(
   parameter int NUM_BLOCKS = sdsp_pkg::NumBlocks,
   parameter int ADDR_W     = $clog2(NUM_BLOCKS * sdsp_pkg::BlockBytes)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 sel_op,
   input  logic [7:0]           byte_in,
   input  logic                 sel_on,
   input  logic                 disk_present,
   input  logic [7:0]           rd_data,
   input  logic                 copy_busy,
   output logic                 done,
   output logic [7:0]           reply,
   output logic [ADDR_W-1:0]    rd_addr,
   output sdsp_pkg::buf_wr_type buf_wr,
   output logic                 copy_start,
   output logic [ADDR_W-1:0]    copy_base
);
   typedef enum logic [3:0] {
      E_IDLE = 4'b0001, E_READ = 4'b0010, E_EXEC = 4'b0100, E_COPY = 4'b1000
   } eng_type;
   typedef enum logic [5:0] {
      M_IDLE = 6'b000001, M_CMD = 6'b000010, M_RESP = 6'b000100,
      M_TOKEN = 6'b001000, M_RECV = 6'b010000, M_CRC = 6'b100000
   } mode_type;
   typedef enum logic [3:0] {
      K_BYTE = 4'b0001, K_CMD8 = 4'b0010, K_CMD58 = 4'b0100, K_READ = 4'b1000
   } kind_type;

   localparam logic [7:0] TOKEN  = 8'hFE;
   localparam logic [7:0] DRESP  = 8'h05;
   localparam logic [5:0] IDX_WR = sdsp_pkg::CMD_WRITE_BLOCK;
   localparam logic [9:0] RD_LEN = 10'(sdsp_pkg::BlockBytes + 4);

   eng_type    st_ff, st_in;
   mode_type   mode_ff, mode_in;
   kind_type   kind_ff, kind_in;
   logic       sel_ff, sel_in;
   logic [7:0] cmd0_ff, cmd0_in;
   logic [31:0] arg_ff, arg_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [7:0] rval_ff, rval_in;
   logic [9:0] rlen_ff, rlen_in;
   logic [9:0] pos_ff, pos_in;
   logic       rdok_ff, rdok_in;
   logic [9:0] rcv_ff, rcv_in;
   logic [31:0] wblk_ff, wblk_in;
   logic [7:0] reply_ff, reply_in;
   logic [7:0] byte_ff;
   logic       selop_ff, on_ff;
   logic [7:0] rbyte;
   logic       cp_go;

   always_comb begin
      case (kind_ff)
         K_BYTE: rbyte = rval_ff;
         K_CMD8: begin
            case (pos_ff)
               10'd0, 10'd3: rbyte = 8'h01;
               10'd1, 10'd2: rbyte = 8'h00;
               default:      rbyte = arg_ff[7:0];
            endcase
         end
         K_CMD58: begin
            case (pos_ff)
               10'd1:   rbyte = 8'hC0;
               10'd2:   rbyte = 8'hFF;
               10'd3:   rbyte = 8'h80;
               default: rbyte = 8'h00;
            endcase
         end
         K_READ: begin
            if (pos_ff == 10'd0)         rbyte = 8'h00;
            else if (pos_ff == 10'd1)    rbyte = TOKEN;
            else if (pos_ff >= RD_LEN - 10'd2) rbyte = 8'hFF;
            else                         rbyte = rdok_ff ? rd_data : 8'h00;
         end
         default: rbyte = 8'hFF;
      endcase
   end

   assign rd_addr   = ADDR_W'({arg_ff, 9'(pos_ff - 10'd2)});
   assign copy_base = ADDR_W'({wblk_ff, 9'd0});

   always_comb begin
      st_in = st_ff; mode_in = mode_ff; kind_in = kind_ff; sel_in = sel_ff;
      cmd0_in = cmd0_ff; arg_in = arg_ff; cnt_in = cnt_ff; rval_in = rval_ff;
      rlen_in = rlen_ff; pos_in = pos_ff; rdok_in = rdok_ff; rcv_in = rcv_ff;
      wblk_in = wblk_ff; reply_in = reply_ff;
      buf_wr = '0; cp_go = 1'b0; done = 1'b0;
      case (st_ff)
         E_IDLE: if (start) st_in = E_READ;
         E_READ: st_in = E_EXEC;
         E_EXEC: begin
            reply_in = 8'hFF;
            if (selop_ff) begin
               reply_in = 8'h00;
               if (!on_ff && sel_ff && mode_ff == M_CMD) begin
                  cnt_in  = '0;
                  mode_in = M_IDLE;
               end
               sel_in = on_ff;
            end else if (sel_ff) begin
               case (mode_ff)
                  M_CMD: begin
                     case (cnt_ff)
                        3'd0:    cmd0_in = byte_ff;
                        3'd1:    arg_in[31:24] = byte_ff;
                        3'd2:    arg_in[23:16] = byte_ff;
                        3'd3:    arg_in[15:8]  = byte_ff;
                        3'd4:    arg_in[7:0]   = byte_ff;
                        default: ;
                     endcase
                     cnt_in = cnt_ff + 3'd1;
                     if (cnt_ff >= 3'd5) begin
                        cnt_in  = '0;
                        pos_in  = '0;
                        mode_in = M_RESP;
                        kind_in = K_BYTE;
                        rval_in = 8'h00;
                        rlen_in = 10'd1;
                        case (cmd0_ff[5:0])
                           sdsp_pkg::CMD_GO_IDLE: rval_in = 8'h01;
                           sdsp_pkg::CMD_SEND_IF: begin
                              kind_in = K_CMD8;
                              rlen_in = 10'd5;
                           end
                           sdsp_pkg::CMD_READ_OCR: begin
                              kind_in = K_CMD58;
                              rlen_in = 10'd5;
                           end
                           sdsp_pkg::CMD_READ_BLOCK: begin
                              kind_in = K_READ;
                              rlen_in = RD_LEN;
                              rdok_in = disk_present && arg_ff < 32'(NUM_BLOCKS);
                           end
                           IDX_WR: wblk_in = arg_ff;
                           default: ;
                        endcase
                     end
                  end
                  M_RESP: begin
                     if (pos_ff < rlen_ff) begin
                        reply_in = rbyte;
                        pos_in   = pos_ff + 10'd1;
                     end
                     if (pos_in >= rlen_ff) begin
                        rlen_in = '0;
                        pos_in  = '0;
                        mode_in = (cmd0_ff[5:0] == IDX_WR) ? M_TOKEN : M_IDLE;
                     end
                  end
                  M_TOKEN: begin
                     if (byte_ff == TOKEN) begin
                        rcv_in  = '0;
                        mode_in = M_RECV;
                     end
                  end
                  M_RECV: begin
                     buf_wr.we   = 1'b1;
                     buf_wr.addr = rcv_ff[8:0];
                     buf_wr.data = byte_ff;
                     rcv_in = rcv_ff + 10'd1;
                     if (rcv_in >= 10'(sdsp_pkg::BlockBytes)) begin
                        cp_go   = disk_present && wblk_ff < 32'(NUM_BLOCKS);
                        rcv_in  = '0;
                        mode_in = M_CRC;
                     end
                  end
                  M_CRC: begin
                     rcv_in = rcv_ff + 10'd1;
                     if (rcv_in >= 10'd2) begin
                        kind_in = K_BYTE;
                        rval_in = DRESP;
                        rlen_in = 10'd1;
                        pos_in  = '0;
                        rcv_in  = '0;
                        mode_in = M_RESP;
                        cmd0_in = 8'h00;
                     end
                  end
                  default: begin
                     mode_in = M_IDLE;
                     if (byte_ff[7:6] == 2'b01) begin
                        cmd0_in = byte_ff;
                        cnt_in  = 3'd1;
                        mode_in = M_CMD;
                     end
                  end
               endcase
            end
            if (cp_go) begin
               st_in = E_COPY;
            end else begin
               st_in = E_IDLE;
               done  = 1'b1;
            end
         end
         E_COPY: begin
            if (!copy_busy) begin
               st_in = E_IDLE;
               done  = 1'b1;
            end
         end
         default: st_in = E_IDLE;
      endcase
   end

   assign copy_start = cp_go;
   assign reply      = (st_ff == E_EXEC) ? reply_in : reply_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= E_IDLE;
         mode_ff <= M_IDLE;
         kind_ff <= K_BYTE;
         sel_ff  <= 1'b0;
         cmd0_ff <= '0;
         arg_ff  <= '0;
         cnt_ff  <= '0;
         rlen_ff <= '0;
         pos_ff  <= '0;
         rdok_ff <= 1'b0;
         rcv_ff  <= '0;
         wblk_ff <= '0;
      end else begin
         st_ff   <= st_in;
         mode_ff <= mode_in;
         kind_ff <= kind_in;
         sel_ff  <= sel_in;
         cmd0_ff <= cmd0_in;
         arg_ff  <= arg_in;
         cnt_ff  <= cnt_in;
         rlen_ff <= rlen_in;
         pos_ff  <= pos_in;
         rdok_ff <= rdok_in;
         rcv_ff  <= rcv_in;
         wblk_ff <= wblk_in;
      end
   end

   always_ff @(posedge clock) begin
      rval_ff  <= rval_in;
      reply_ff <= reply_in;
      if (start && st_ff == E_IDLE) begin
         byte_ff  <= byte_in;
         selop_ff <= sel_op;
         on_ff    <= sel_on;
      end
   end
endmodule

[rtl/sd_card_spi_slave_top.sv]
// ----------------------------------------------------------------------------
// sd_card_spi_slave_top
// SD card in SPI mode: command decode, block read and block write.
// ----------------------------------------------------------------------------
// Input channel req_*: func 0 swaps one byte (req_mosi[7:0]), func 1 swaps
// four bytes low byte first, func 2 sets chip select from req_select_on.
// Result channel rsp_*: one word per request, card bytes in rsp_miso.
// csr_we/csr_wdata write disk_present; take effect on the next request.
// One request at a time: req_ready is low from acceptance until its result
// is loaded into the output register. Each byte or select runs through the
// shared byte engine (start, store read, execute); a word runs its four bytes in turn.
// The byte that completes a block write with the disk present and the block
// in range also copies the receive buffer into the store before it is done.
// Reset: the store is cleared one byte per cycle, all NUM_BLOCKS * BLOCK_BYTES
// bytes, with req_ready low throughout; csr writes are taken as usual.
// A stalled receiver holds the result in the output register; the next
// request may be accepted meanwhile and waits for the register to free up.
// ----------------------------------------------------------------------------
module sd_card_spi_slave_top #(
   parameter int NUM_BLOCKS = sdsp_pkg::NumBlocks
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_mosi,
   input  logic        req_select_on,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_miso,
   input  logic        csr_we,
   input  logic        csr_wdata
);
   localparam int DEPTH  = NUM_BLOCKS * sdsp_pkg::BlockBytes;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [3:0] {
      T_IDLE = 4'b0001, T_START = 4'b0010, T_WAIT = 4'b0100, T_PUSH = 4'b1000
   } top_type;

   top_type     st_ff, st_in;
   logic [1:0]  func_ff;
   logic [31:0] mosi_ff;
   logic        on_ff;
   logic [1:0]  k_ff, k_in;
   logic [31:0] res_ff, res_in;
   logic        rsp_valid_ff;
   logic [31:0] rsp_miso_ff;
   logic        present_ff;

   logic                 eng_start, eng_done, store_busy, copy_start;
   logic [7:0]           eng_reply, rd_data;
   logic [ADDR_W-1:0]    rd_addr, copy_base;
   sdsp_pkg::buf_wr_type buf_wr;
   logic                 accept, push;

   assign accept    = req_valid && req_ready;
   assign req_ready = (st_ff == T_IDLE) && !store_busy;
   assign push      = (st_ff == T_PUSH) && (!rsp_valid_ff || rsp_ready);
   assign eng_start = (st_ff == T_START);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_miso  = rsp_miso_ff;

   always_comb begin
      st_in  = st_ff;
      k_in   = k_ff;
      res_in = res_ff;
      case (st_ff)
         T_IDLE: begin
            if (accept) begin
               res_in = '0;
               k_in   = '0;
               st_in  = (req_func == sdsp_pkg::FUNC_NONE) ? T_PUSH : T_START;
            end
         end
         T_START: st_in = T_WAIT;
         T_WAIT: begin
            if (eng_done) begin
               if (func_ff != sdsp_pkg::FUNC_SEL) res_in[{k_ff, 3'b000} +: 8] = eng_reply;
               if (func_ff == sdsp_pkg::FUNC_WORD && k_ff != 2'd3) begin
                  k_in  = k_ff + 2'd1;
                  st_in = T_START;
               end else begin
                  st_in = T_PUSH;
               end
            end
         end
         T_PUSH: if (push) st_in = T_IDLE;
         default: st_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= T_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         present_ff   <= 1'b1;
      end else begin
         st_ff <= st_in;
         k_ff  <= k_in;
         if (push) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_we) present_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (push) rsp_miso_ff <= res_ff;
      if (accept) begin
         func_ff <= req_func;
         mosi_ff <= req_mosi;
         on_ff   <= req_select_on;
      end
   end

   sdsp_engine #(.NUM_BLOCKS(NUM_BLOCKS), .ADDR_W(ADDR_W)) u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (eng_start),
      .sel_op       (func_ff == sdsp_pkg::FUNC_SEL),
      .byte_in      (mosi_ff[{k_ff, 3'b000} +: 8]),
      .sel_on       (on_ff),
      .disk_present (present_ff),
      .rd_data      (rd_data),
      .copy_busy    (store_busy),
      .done         (eng_done),
      .reply        (eng_reply),
      .rd_addr      (rd_addr),
      .buf_wr       (buf_wr),
      .copy_start   (copy_start),
      .copy_base    (copy_base)
   );

   sdsp_store #(.NUM_BLOCKS(NUM_BLOCKS), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .buf_wr     (buf_wr),
      .copy_start (copy_start),
      .copy_base  (copy_base),
      .busy       (store_busy)
   );
endmodule

[rtl/sdsp_checker.sv]
// ----------------------------------------------------------------------------
// sdsp_checker
// Port-level checks for the SD card SPI slave, bound to the top level.
// ----------------------------------------------------------------------------
`include "sd_card_spi_slave_top_assert.svh"

module sdsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_miso
);
   `SDSP_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_miso))
   `SDSP_ASSERT_NXT(a_one_word, req_valid && req_ready, !req_ready)
   `SDSP_ASSERT_IMP(a_rsp_known, rsp_valid, !$isunknown(rsp_miso))
endmodule

bind sd_card_spi_slave_top sdsp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_miso  (rsp_miso)
);
